// ----- hw/rtl/ggp_pkg.sv -----
// shared types, constants and helper functions for the glyph grid packer
`default_nettype none

package ggp_pkg;

  // fnv-1a 64 constants
  localparam logic [63:0] HashBasis = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] HashPrime = 64'h0000_0100_0000_01B3;

  // prefix lengths of the signature line and the text line
  localparam int unsigned HdrLen = 26;
  localparam int unsigned TxtLen = 5;

  // rows per grid and cells per row
  localparam int unsigned GridRows  = 8;
  localparam int unsigned RowCells  = 8;
  localparam int unsigned RowIdxW   = $clog2(GridRows);

  // character codes
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChNl   = 8'h0A;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] ChHash = 8'h23;

  // summary of a line that closes in the current cycle
  typedef struct packed {
    logic       fire;
    logic       is_header;
    logic       is_row;
    logic [7:0] bits;
  } line_close_t;

  // expected byte of the signature line at a given position
  function automatic logic [7:0] hdr_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h53;
      5'd1:    b = 8'h48;
      5'd2:    b = 8'h41;
      5'd3:    b = 8'h4B;
      5'd4:    b = 8'h54;
      5'd5:    b = 8'h49;
      5'd6:    b = 8'h5F;
      5'd7:    b = 8'h57;
      5'd8:    b = 8'h52;
      5'd9:    b = 8'h49;
      5'd10:   b = 8'h54;
      5'd11:   b = 8'h54;
      5'd12:   b = 8'h45;
      5'd13:   b = 8'h4E;
      5'd14:   b = 8'h5F;
      5'd15:   b = 8'h54;
      5'd16:   b = 8'h45;
      5'd17:   b = 8'h58;
      5'd18:   b = 8'h54;
      5'd19:   b = 8'h5F;
      5'd20:   b = 8'h38;
      5'd21:   b = 8'h58;
      5'd22:   b = 8'h38;
      5'd23:   b = 8'h5F;
      5'd24:   b = 8'h56;
      5'd25:   b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // expected byte of the text line prefix
  function automatic logic [7:0] txt_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h54;
      3'd1:    b = 8'h45;
      3'd2:    b = 8'h58;
      3'd3:    b = 8'h54;
      3'd4:    b = 8'h3D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one fnv-1a step; the prime is sparse so the product is a few shifted adds
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ggp_line_unit.sv -----
// line splitter: prefix matching and cell packing for the current line
`default_nettype none

module ggp_line_unit import ggp_pkg::*; #(
  parameter int unsigned LineBuffer = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        char_valid_i,
  input  wire logic        last_i,
  output line_close_t      close_o
);

  localparam int unsigned PosW = $clog2(LineBuffer);

  logic [PosW-1:0] pos_q, pos_d, pos_n;
  logic            hm_q, hm_d, hm_n;
  logic            tm_q, tm_d, tm_n;
  logic            stop_q, stop_d, stop_n;
  logic [3:0]      cnt_q, cnt_d, cnt_n;
  logic [7:0]      bits_q, bits_d, bits_n;
  logic            take;
  logic            byte_close;
  logic            line_close;

  // fold the incoming byte into the line state
  always_comb begin
    take   = step_i && char_valid_i;
    pos_n  = pos_q;
    hm_n   = hm_q;
    tm_n   = tm_q;
    stop_n = stop_q;
    cnt_n  = cnt_q;
    bits_n = bits_q;
    if (take) begin
      if (pos_q < PosW'(HdrLen) && char_code_i != hdr_byte(pos_q[4:0])) begin
        hm_n = 1'b0;
      end
      if (pos_q < PosW'(TxtLen) && char_code_i != txt_byte(pos_q[2:0])) begin
        tm_n = 1'b0;
      end
      pos_n = pos_q + 1'b1;
      if (!stop_q) begin
        if (char_code_i == ChNul || char_code_i == ChNl || char_code_i == ChCr) begin
          stop_n = 1'b1;
        end else if (char_code_i == ChDot || char_code_i == ChHash) begin
          bits_n = {bits_q[6:0], char_code_i == ChHash};
          if (cnt_q != 4'hF) begin
            cnt_n = cnt_q + 4'd1;
          end
        end
      end
    end
  end

  // line ends at newline, at the buffer limit, or at end of file
  always_comb begin
    byte_close = take && (char_code_i == ChNl || pos_n >= PosW'(LineBuffer - 1));
    line_close = byte_close || (step_i && last_i && pos_n != '0);
  end

  // classify the closing line
  always_comb begin
    close_o.fire      = line_close;
    close_o.is_header = hm_n && pos_n >= PosW'(HdrLen);
    close_o.is_row    = !close_o.is_header && !(tm_n && pos_n >= PosW'(TxtLen)) &&
                        cnt_n == 4'(RowCells);
    close_o.bits      = bits_n;
  end

  // next line state: cleared once a line closes or the file ends
  always_comb begin
    if (line_close || (step_i && last_i)) begin
      pos_d  = '0;
      hm_d   = 1'b1;
      tm_d   = 1'b1;
      stop_d = 1'b0;
      cnt_d  = '0;
      bits_d = '0;
    end else begin
      pos_d  = pos_n;
      hm_d   = hm_n;
      tm_d   = tm_n;
      stop_d = stop_n;
      cnt_d  = cnt_n;
      bits_d = bits_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hm_q   <= 1'b1;
      tm_q   <= 1'b1;
      stop_q <= 1'b0;
      cnt_q  <= '0;
      bits_q <= '0;
    end else begin
      pos_q  <= pos_d;
      hm_q   <= hm_d;
      tm_q   <= tm_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
      bits_q <= bits_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/glyph_grid_pack_and_hash_core.sv -----
// glyph grid packer top level: input register, grid and hash state, result register
//
// Input channel (in_valid_i / in_stall_o) carries one file byte per transaction
// in char_code_i, qualified by char_valid_i; last_i marks the end of the file.
// An item with char_valid_i low and last_i low does nothing.
// Output channel (out_valid_o / out_stall_i) carries one result per file: the
// status, the eight rows of the first grid, the row hash and the grid count.
// Throughput: one byte per cycle while in_stall_o is low. The line, hash and
// grid update is a single combinational step between the input register and
// the state registers; the hash multiply is a fixed set of shifted adds.
// out_valid_o rises once the transaction carrying last_i has passed the input
// register and reached the result register, taken when out_stall_i is low.
// While a result waits under out_stall_i, ordinary bytes keep flowing; only a
// second end-of-file item holds in the input register, and in_stall_o rises.
// Reset clears both registers and returns the line, grid and hash state to
// their start values; after every result the state starts over for the next
// file.
`default_nettype none

module glyph_grid_pack_and_hash_core import ggp_pkg::*; #(
  parameter int unsigned LineBuffer = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        char_valid_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic [7:0]       grid_row_0_o,
  output logic [7:0]       grid_row_1_o,
  output logic [7:0]       grid_row_2_o,
  output logic [7:0]       grid_row_3_o,
  output logic [7:0]       grid_row_4_o,
  output logic [7:0]       grid_row_5_o,
  output logic [7:0]       grid_row_6_o,
  output logic [7:0]       grid_row_7_o,
  output logic [63:0]      row_hash_o,
  output logic [15:0]      grid_count_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_code_q;
  logic       s1_cv_q;
  logic       s1_last_q;
  logic       in_accept;
  logic       s1_fire;
  logic       file_end;

  // file state
  logic [63:0]        hash_q, hash_d, hash_n;
  logic [15:0]        grids_q, grids_d, grids_n;
  logic [RowIdxW-1:0] ridx_q, ridx_d, ridx_n;
  logic               hdr_q, hdr_d, hdr_n;
  logic [7:0]         grid_q [GridRows];
  logic [7:0]         grid_d [GridRows];
  logic [7:0]         grid_n [GridRows];
  logic               row_done;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        out_status_q;
  logic [7:0]  out_grid_q [GridRows];
  logic [63:0] out_hash_q;
  logic [15:0] out_count_q;

  line_close_t lc;

  // input handshake: only an end-of-file item waits for the result register
  always_comb begin
    s1_fire    = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
    in_stall_o = s1_valid_q && !s1_fire;
    in_accept  = in_valid_i && !in_stall_o;
    s1_valid_d = in_accept || (s1_valid_q && !s1_fire);
    file_end   = s1_fire && s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_code_q <= char_code_i;
      s1_cv_q   <= char_valid_i;
      s1_last_q <= last_i;
    end
  end

  ggp_line_unit #(
    .LineBuffer (LineBuffer)
  ) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_fire),
    .char_code_i  (s1_code_q),
    .char_valid_i (s1_cv_q),
    .last_i       (s1_last_q),
    .close_o      (lc)
  );

  // grid, hash and count update for a closing line
  always_comb begin
    row_done = lc.fire && lc.is_row;
    hdr_n    = hdr_q || (lc.fire && lc.is_header);
    hash_n   = row_done ? fnv_fold(hash_q, lc.bits) : hash_q;
    ridx_n   = row_done ? ridx_q + 1'b1 : ridx_q;
    grids_n  = grids_q;
    if (row_done && ridx_q == RowIdxW'(GridRows - 1) && grids_q != 16'hFFFF) begin
      grids_n = grids_q + 16'd1;
    end
    for (int i = 0; i < GridRows; i++) begin
      grid_n[i] = grid_q[i];
    end
    if (row_done && grids_q == '0) begin
      grid_n[ridx_q] = lc.bits;
    end
  end

  // state restarts after each end of file
  always_comb begin
    if (file_end) begin
      hash_d  = HashBasis;
      grids_d = '0;
      ridx_d  = '0;
      hdr_d   = 1'b0;
      for (int i = 0; i < GridRows; i++) begin
        grid_d[i] = '0;
      end
    end else begin
      hash_d  = hash_n;
      grids_d = grids_n;
      ridx_d  = ridx_n;
      hdr_d   = hdr_n;
      for (int i = 0; i < GridRows; i++) begin
        grid_d[i] = grid_n[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= HashBasis;
      grids_q <= '0;
      ridx_q  <= '0;
      hdr_q   <= 1'b0;
      for (int i = 0; i < GridRows; i++) begin
        grid_q[i] <= '0;
      end
    end else begin
      hash_q  <= hash_d;
      grids_q <= grids_d;
      ridx_q  <= ridx_d;
      hdr_q   <= hdr_d;
      for (int i = 0; i < GridRows; i++) begin
        grid_q[i] <= grid_d[i];
      end
    end
  end

  // result register
  assign out_valid_d = file_end || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (file_end) begin
      out_status_q <= !hdr_n || grids_n == '0 || ridx_n != '0;
      out_hash_q   <= hash_n;
      out_count_q  <= grids_n;
      for (int i = 0; i < GridRows; i++) begin
        out_grid_q[i] <= grid_n[i];
      end
    end
  end

  // output ports
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign grid_row_0_o = out_grid_q[0];
  assign grid_row_1_o = out_grid_q[1];
  assign grid_row_2_o = out_grid_q[2];
  assign grid_row_3_o = out_grid_q[3];
  assign grid_row_4_o = out_grid_q[4];
  assign grid_row_5_o = out_grid_q[5];
  assign grid_row_6_o = out_grid_q[6];
  assign grid_row_7_o = out_grid_q[7];
  assign row_hash_o   = out_hash_q;
  assign grid_count_o = out_count_q;

  // state is back at its start values after a file ends
  a_file_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    file_end |=> (grids_q == '0 && ridx_q == '0 && hash_q == HashBasis && !hdr_q))
    else $error("file state not restarted after end of file");

  // the input only stalls behind a held result for a second end-of-file item
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q && out_stall_i))
    else $error("input stalled without a pending result");

  // a pure result always has at least one complete grid
  a_pure_has_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (grid_count_o != '0))
    else $error("pure status with zero grids");

  // a new result is loaded only into an empty or draining result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    file_end |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the glyph grid packer and row hash core
`default_nettype none

module tb_top;

  localparam int LineBuf = 256;
  localparam int SigLen  = 26;
  localparam int TagLen  = 5;

  // fnv-1a 64 constants
  localparam logic [63:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01B3;

  // character codes
  localparam logic [7:0] CNul  = 8'h00;
  localparam logic [7:0] CLf   = 8'h0A;
  localparam logic [7:0] CCr   = 8'h0D;
  localparam logic [7:0] CDot  = 8'h2E;
  localparam logic [7:0] CHash = 8'h23;

  // signature line text and text line tag, first byte at index 0
  localparam logic [0:SigLen-1][7:0] SigText =
    {8'h53, 8'h48, 8'h41, 8'h4B, 8'h54, 8'h49, "_WRITTEN_TEXT_8X8_V1"};
  localparam logic [0:TagLen-1][7:0] TextTag = "TEXT=";

  // one result of a file
  typedef struct packed {
    logic            status;
    logic [7:0][7:0] rows;
    logic [63:0]     hash;
    logic [15:0]     count;
  } glyph_result_t;

  localparam glyph_result_t NoGrid =
    '{status: 1'b1, rows: '0, hash: FnvBasis, count: 16'd0};

  // how a directed file opens
  typedef enum logic [1:0] {SigNone, SigLine, SigBare, SigShort} sig_lead_e;

  // directed file: lead, prefix, fill run, body repeated, end mark choice
  typedef struct {
    sig_lead_e     lead;
    string         prefix;
    int            fill;
    logic [7:0]    fill_ch;
    string         body;
    int            reps;
    int            nul_at;
    bit            end_only;
    bit            typed;
    glyph_result_t want;
  } glyph_file_t;

  localparam string Cross =
    "#......#\n.#....#.\n..#..#..\n...##...\n...##...\n..#..#..\n.#....#.\n#......#\n";
  localparam string CrossOpen =
    "#......#\n.#....#.\n..#..#..\n...##...\n...##...\n..#..#..\n.#....#.\n#......#";
  localparam string Edges =
    "########\n........\n#.#.#.#.\n.#.#.#.#\n####....\n....####\n##..##..\n..##..##\n";

  glyph_file_t dir_files[] = '{
    // empty file, end mark alone
    '{SigNone,  "", 0, "a", "", 0, -1, 1'b1, 1'b1, NoGrid},
    // signature only, end on its newline
    '{SigLine,  "", 0, "a", "", 0, -1, 1'b0, 1'b1, NoGrid},
    // signature left open at end of file
    '{SigBare,  "", 0, "a", "", 0, -1, 1'b0, 1'b1, NoGrid},
    // text line with cells is skipped
    '{SigLine,  "TEXT=#.#.#.#.\n", 0, "a", "", 0, -1, 1'b1, 1'b1, NoGrid},
    // too many cells on one line
    '{SigNone,  "", 20, "#", "\n", 1, -1, 1'b0, 1'b1, NoGrid},
    // a full buffer of dots closes itself, not a row
    '{SigNone,  "", 255, ".", "", 0, -1, 1'b1, 1'b1, NoGrid},
    // clean single grid
    '{SigLine,  "", 0, "a", Cross, 1, -1, 1'b0, 1'b0, NoGrid},
    // extreme row values
    '{SigLine,  "", 0, "a", Edges, 1, -1, 1'b0, 1'b0, NoGrid},
    // grid without signature
    '{SigNone,  "", 0, "a", Cross, 1, -1, 1'b0, 1'b0, NoGrid},
    // signature one byte short
    '{SigShort, "", 0, "a", Cross, 1, -1, 1'b0, 1'b0, NoGrid},
    // nul inside the signature
    '{SigLine,  "", 0, "a", Cross, 1, 10, 1'b0, 1'b0, NoGrid},
    // last row closed by the end of file
    '{SigLine,  "", 0, "a", CrossOpen, 1, -1, 1'b0, 1'b0, NoGrid},
    // end mark on an item of its own
    '{SigLine,  "", 0, "a", Cross, 1, -1, 1'b1, 1'b0, NoGrid},
    // partial grid, first grid differs from the second
    '{SigLine,  "##..##..\n", 0, "a", Cross, 2, -1, 1'b0, 1'b0, NoGrid},
    // short text tag, bare tag, nine cells
    '{SigLine,  "TEX#.#.#.#.\nTEXT\n#########\n", 0, "a", Cross, 1, -1, 1'b0, 1'b0, NoGrid},
    // cr and nul stop the cell scan
    '{SigLine,  "........\r\n####x####\n##\r######\n", 0, "a", Cross, 1, 41, 1'b0, 1'b0,
      NoGrid},
    // row that ends at the buffer limit, then an empty line
    '{SigLine,  "", 247, "z", "#######.\n.#######\n", 1, -1, 1'b0, 1'b0, NoGrid},
    // overlong line split in two
    '{SigLine,  "", 300, "y", Cross, 1, -1, 1'b0, 1'b0, NoGrid}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_code_i;
  logic        char_valid_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic [7:0]  grid_row_0_o;
  logic [7:0]  grid_row_1_o;
  logic [7:0]  grid_row_2_o;
  logic [7:0]  grid_row_3_o;
  logic [7:0]  grid_row_4_o;
  logic [7:0]  grid_row_5_o;
  logic [7:0]  grid_row_6_o;
  logic [7:0]  grid_row_7_o;
  logic [63:0] row_hash_o;
  logic [15:0] grid_count_o;

  glyph_grid_pack_and_hash_core #(
    .LineBuffer(LineBuf)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .char_valid_i(char_valid_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .grid_row_0_o(grid_row_0_o),
    .grid_row_1_o(grid_row_1_o),
    .grid_row_2_o(grid_row_2_o),
    .grid_row_3_o(grid_row_3_o),
    .grid_row_4_o(grid_row_4_o),
    .grid_row_5_o(grid_row_5_o),
    .grid_row_6_o(grid_row_6_o),
    .grid_row_7_o(grid_row_7_o),
    .row_hash_o  (row_hash_o),
    .grid_count_o(grid_count_o)
  );

  glyph_result_t   pending_results[$];
  logic [7:0]      file_q[$];
  int              mismatch_count = 0;
  int              tx_idle_pct = 16;
  int              rx_idle_pct = 16;
  int              hold_ask = 0;

  // predicted line and file state
  int              ln_len;
  bit              sig_ok;
  bit              tag_ok;
  bit              cells_off;
  logic [3:0]      n_cells;
  logic [7:0]      cell_bits;
  logic [2:0]      row_no;
  logic [15:0]     grids;
  bit              sig_seen;
  logic [63:0]     fnv;
  logic [7:0][7:0] kept;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  function void line_restart();
    ln_len    = 0;
    sig_ok    = 1'b1;
    tag_ok    = 1'b1;
    cells_off = 1'b0;
    n_cells   = '0;
    cell_bits = '0;
  endfunction

  function void file_restart();
    line_restart();
    row_no   = '0;
    grids    = '0;
    sig_seen = 1'b0;
    fnv      = FnvBasis;
    kept     = '0;
  endfunction

  // classify the closing line: signature, text line, or grid row
  function void line_end();
    if (sig_ok && ln_len >= SigLen) begin
      sig_seen = 1'b1;
    end else if ((!tag_ok || ln_len < TagLen) && n_cells == 4'd8) begin
      if (grids == 16'd0) kept[row_no] = cell_bits;
      fnv = (fnv ^ {56'd0, cell_bits}) * FnvPrime;
      row_no = row_no + 3'd1;
      if (row_no == 3'd0 && grids != 16'hFFFF) grids = grids + 16'd1;
    end
    line_restart();
  endfunction

  // advance the prediction by one transaction; returns 1 with a result at end of file
  function bit glyph_step(input logic [7:0] c, input logic cv, input logic lst,
                          output glyph_result_t r);
    r = NoGrid;
    if (cv) begin
      if (ln_len < SigLen && c != SigText[ln_len]) sig_ok = 1'b0;
      if (ln_len < TagLen && c != TextTag[ln_len]) tag_ok = 1'b0;
      ln_len++;
      if (!cells_off) begin
        if (c == CNul || c == CLf || c == CCr) begin
          cells_off = 1'b1;
        end else if (c == CDot || c == CHash) begin
          cell_bits = {cell_bits[6:0], c == CHash};
          if (n_cells != 4'd15) n_cells = n_cells + 4'd1;
        end
      end
      if (c == CLf || ln_len >= LineBuf - 1) line_end();
    end
    if (!lst) return 1'b0;
    if (ln_len != 0) line_end();
    r.status = !sig_seen || grids == 16'd0 || row_no != 3'd0;
    r.rows   = kept;
    r.hash   = fnv;
    r.count  = grids;
    file_restart();
    return 1'b1;
  endfunction

  // offer one transaction, hold it until accepted, then predict
  task send_item(input logic [7:0] code, input logic cv, input logic lst, input bit typed,
                 input glyph_result_t want);
    glyph_result_t res;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= code;
    char_valid_i <= cv;
    last_i       <= lst;
    do @(posedge clk_i); while (in_stall_o);
    if (glyph_step(code, cv, lst, res)) pending_results.push_back(typed ? want : res);
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task add_text(input string s);
    foreach (s[i]) file_q.push_back(s[i]);
  endtask

  // random cells, optionally with letters in between
  task add_cells(input int n, input bit sprinkle);
    repeat (n) begin
      file_q.push_back($urandom_range(1) ? CHash : CDot);
      if (sprinkle && $urandom_range(1)) file_q.push_back(8'h61 + 8'($urandom_range(25)));
    end
  endtask

  // random file: mostly well-formed grids, with broken lines and noise mixed in
  task build_file();
    int         rows;
    int         sig_at;
    int         k;
    bit         with_sig;
    logic [7:0] b;
    file_q.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 60)) file_q.push_back(8'($urandom_range(255)));
      return;
    end
    with_sig = ($urandom_range(99) < 85);
    k = $urandom_range(19);
    rows = (k == 0) ? 0 : (k == 1) ? 16 : 8;
    if ($urandom_range(99) < 20) rows += $urandom_range(1, 7);
    sig_at = ($urandom_range(99) < 85) ? 0 : $urandom_range(rows);
    for (int r = 0; r <= rows; r++) begin
      // signature line, sometimes damaged, trimmed or extended
      if (with_sig && r == sig_at) begin
        for (int i = 0; i < SigLen; i++) file_q.push_back(SigText[i]);
        k = $urandom_range(9);
        if (k == 0) file_q[file_q.size() - 1 - $urandom_range(SigLen - 1)] =
          8'($urandom_range(255));
        else if (k == 1) add_text(" extra");
        else if (k == 2) void'(file_q.pop_back());
        file_q.push_back(CLf);
      end
      if (r == rows) break;
      // occasional line that is not a grid row
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(5))
          0: begin
            add_text("TEXT=");
            add_cells(8, 1'b0);
          end
          1: repeat ($urandom_range(40)) file_q.push_back(8'($urandom_range(255)));
          2: add_cells($urandom_range(1) ? 9 : 7, 1'b1);
          3: repeat ($urandom_range(250, 300)) begin
            b = 8'($urandom_range(255));
            file_q.push_back(b == CLf ? CDot : b);
          end
          4: begin
            add_cells(4, 1'b0);
            file_q.push_back($urandom_range(1) ? CNul : CCr);
            add_cells(4, 1'b0);
          end
          default: ;
        endcase
        file_q.push_back(CLf);
      end
      // grid row, sometimes with trailing cr or cells after it
      add_cells(8, $urandom_range(99) < 15);
      k = $urandom_range(9);
      if (k == 0) begin
        file_q.push_back(CCr);
      end else if (k == 1) begin
        file_q.push_back(CCr);
        add_cells($urandom_range(1, 4), 1'b0);
      end
      file_q.push_back(CLf);
    end
    if (file_q.size() != 0 && file_q[$] == CLf && $urandom_range(99) < 20)
      void'(file_q.pop_back());
  endtask

  // send the built file with empty items sprinkled in
  task send_file();
    bit end_sep;
    end_sep = (file_q.size() == 0) || ($urandom_range(99) < 30);
    foreach (file_q[i]) begin
      if ($urandom_range(99) < 3) send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NoGrid);
      send_item(file_q[i], 1'b1, !end_sep && i == file_q.size() - 1, 1'b0, NoGrid);
    end
    if (end_sep) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NoGrid);
  endtask

  // directed files, streamed byte by byte
  task run_directed();
    int          total;
    int          lead_len;
    int          p;
    logic [7:0]  b;
    glyph_file_t f;
    foreach (dir_files[n]) begin
      f = dir_files[n];
      lead_len = (f.lead == SigNone) ? 0 : (f.lead == SigLine) ? SigLen + 1 : SigLen;
      total = lead_len + f.prefix.len() + f.fill + f.body.len() * f.reps;
      tx_idle_pct = (f.reps > 1000) ? 0 : 16;
      rx_idle_pct = tx_idle_pct;
      for (int i = 0; i < total; i++) begin
        p = i;
        if (p < lead_len) begin
          b = (p == lead_len - 1 && f.lead != SigBare) ? CLf : SigText[p];
        end else begin
          p -= lead_len;
          if (p < f.prefix.len()) begin
            b = f.prefix[p];
          end else begin
            p -= f.prefix.len();
            b = (p < f.fill) ? f.fill_ch : f.body[(p - f.fill) % f.body.len()];
          end
        end
        if (i == f.nul_at) b = CNul;
        send_item(b, 1'b1, !f.end_only && i == total - 1, f.typed, f.want);
      end
      if (f.end_only) send_item(8'($urandom_range(255)), 1'b0, 1'b1, f.typed, f.want);
    end
    tx_idle_pct = 16;
    rx_idle_pct = 16;
  endtask

  // stimulus
  initial begin
    int rand_items;
    int files_sent;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    char_code_i  = '0;
    char_valid_i = 1'b0;
    last_i       = 1'b0;
    rand_items   = 0;
    files_sent   = 0;
    file_restart();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    // long receiver hold while short files keep coming
    hold_ask <= hold_ask + 1;
    repeat (6) begin
      file_q.delete();
      add_cells(8, 1'b0);
      file_q.push_back(CLf);
      send_file();
    end

    // random files until enough bytes and results
    while (rand_items < 600 || files_sent < 8) begin
      if (files_sent == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (files_sent == 6) begin
        tx_idle_pct = 16;
        rx_idle_pct = 16;
        wait_drained();
      end
      build_file();
      rand_items += file_q.size() + 1;
      send_file();
      files_sent++;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stalls, plus a long hold on request
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task note_bad(input string what, input logic [63:0] exp_val, input logic [63:0] act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, exp_val, act_val);
  endtask

  // compare each accepted result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    glyph_result_t got;
    glyph_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.rows   = {grid_row_7_o, grid_row_6_o, grid_row_5_o, grid_row_4_o,
                    grid_row_3_o, grid_row_2_o, grid_row_1_o, grid_row_0_o};
      got.hash   = row_hash_o;
      got.count  = grid_count_o;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result transaction with none pending");
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) note_bad("status", 64'(want.status), 64'(got.status));
        for (int k = 0; k < 8; k++)
          if (got.rows[k] != want.rows[k])
            note_bad($sformatf("grid_row_%0d", k), 64'(want.rows[k]), 64'(got.rows[k]));
        if (got.hash != want.hash) note_bad("row_hash", want.hash, got.hash);
        if (got.count != want.count) note_bad("grid_count", 64'(want.count), 64'(got.count));
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/ggp_pkg.sv
hw/rtl/ggp_line_unit.sv
hw/rtl/glyph_grid_pack_and_hash_core.sv
tb/tb_top.sv
